[hdl/bss_pkg.sv]
// ---------------------------------------------------------------------------
// bss_pkg
// Types and codes shared by the bundle slot store blocks.
// ---------------------------------------------------------------------------
package bss_pkg;

	// width of a page number as kept in a slot record
	localparam int PAGE_W = 8;

	// request codes
	localparam logic [2:0] REQ_SAVE   = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_LOOKUP = 3'd2;
	localparam logic [2:0] REQ_LOCK   = 3'd3;
	localparam logic [2:0] REQ_UNLOCK = 3'd4;
	localparam logic [2:0] REQ_PRUNE  = 3'd5;

	// completion status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ALREADY   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NO_ROOM   = 2'd3;

	// removal reasons
	localparam logic [1:0] RSN_EXPIRED   = 2'd0;
	localparam logic [1:0] RSN_DEPLETED  = 2'd1;
	localparam logic [1:0] RSN_DELIVERED = 2'd2;
	localparam logic [1:0] RSN_OTHER     = 2'd3;

	// event kinds
	localparam logic KIND_DONE   = 1'b0;
	localparam logic KIND_NOTICE = 1'b1;

	// eviction policies
	localparam logic [2:0] POL_NEVER    = 3'd0;
	localparam logic [2:0] POL_EARLIEST = 3'd1;
	localparam logic [2:0] POL_LATEST   = 3'd2;
	localparam logic [2:0] POL_OLDER    = 3'd3;
	localparam logic [2:0] POL_YOUNGER  = 3'd4;
	localparam logic [2:0] POL_RESET    = POL_EARLIEST;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] bundle_id;
		logic [1:0]  priority_req;
		logic        wants_report;
		logic        from_local_node;
		logic [31:0] expiry_time;
		logic [31:0] now_seconds;
		logic        delivered;
	} in_word_t;

	typedef struct packed {
		logic        last;
		logic        event_kind;
		logic [1:0]  status;
		logic [31:0] result_bundle;
		logic [5:0]  result_page;
		logic [1:0]  removal_reason;
		logic        report_needed;
		logic [4:0]  stored_count;
	} out_word_t;

	typedef struct packed {
		logic [31:0]       number;
		logic [31:0]       expiry;
		logic [1:0]        prio;
		logic              locked;
		logic              report;
		logic              local_src;
		logic [PAGE_W-1:0] page;
	} slot_rec_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PR_RD,
		S_PR_CHK,
		S_VI_RD,
		S_VI_CHK,
		S_VI_REM,
		S_FD_RD,
		S_FD_CHK,
		S_DEL,
		S_MOD,
		S_PROBE,
		S_STORE,
		S_DONE
	} state_t;

endpackage

[hdl/bss_mem.sv]
// ---------------------------------------------------------------------------
// bss_mem
// Slot record memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bss_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic [AW-1:0]       rd_addr,
	output bss_pkg::slot_rec_t  rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bss_pkg::slot_rec_t  wr_data
);
	import bss_pkg::*;

	slot_rec_t mem [DEPTH];
	slot_rec_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/bss_ctrl.sv]
// ---------------------------------------------------------------------------
// bss_ctrl
// Request sequencer: walks slots in insertion order over the record memory,
// removes, evicts, finds, probes pages and stores; emits result words.
// ---------------------------------------------------------------------------
module bss_ctrl #(
	parameter int SLOTS = 16,
	parameter int PAGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bss_pkg::in_word_t  in_data,
	input  logic [2:0]         policy,
	output logic               emit_valid,
	input  logic               emit_ready,
	output bss_pkg::out_word_t emit_word
);
	import bss_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int TW    = $clog2(PAGES + 1);
	localparam int TAB_N = 256;

	// residue tables: entry k holds (k * mul) mod PAGES
	function automatic logic [TAB_N*PGW-1:0] mk_tab(int mul);
		logic [TAB_N*PGW-1:0] t;
		t = '0;
		for (int k = 0; k < TAB_N; k++) begin
			t[k*PGW +: PGW] = PGW'((k * mul) % PAGES);
		end
		return t;
	endfunction

	localparam logic [TAB_N*PGW-1:0] SHL_TAB = mk_tab(256);
	localparam logic [TAB_N*PGW-1:0] DIG_TAB = mk_tab(1);

	state_t            st_q, st_d;
	in_word_t          req_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     cnt_q;
	logic [SW-1:0]     ord_q [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [PAGES-1:0]  pused_q;
	logic              best_found_q;
	logic [CW-1:0]     best_pos_q;
	slot_rec_t         best_rec_q;
	slot_rec_t         hit_rec_q;
	logic [PGW-1:0]    page_q;
	logic [TW-1:0]     tries_q;
	logic [1:0]        dig_q;
	logic [1:0]        cstat_q;
	logic [31:0]       cnum_q;
	logic [5:0]        cpage_q;

	logic [SW-1:0]     rd_addr;
	slot_rec_t         rd_data;
	logic              wr_en;
	logic [SW-1:0]     wr_addr;
	slot_rec_t         wr_data;

	logic              rm_en;
	logic [CW-1:0]     rm_pos;
	slot_rec_t         rm_rec;

	logic              at_end, full, pol_walk, expired, eligible, better, first_mode, hit;
	logic              free_found;
	logic [SW-1:0]     free_idx;
	logic [7:0]        dig_val, shl_idx;
	logic [PGW-1:0]    shl_r, dig_r;
	logic [PGW:0]      mod_t, mod_r;
	logic [CW+4:0]     cnt_ext, cnt_dec_ext;
	slot_rec_t         new_rec;

	bss_mem #(.DEPTH(SLOTS), .AW(SW)) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// walk address follows the insertion order list
	assign rd_addr = ord_q[pos_q[SW-1:0]];

	// per-entry tests on the record just read
	assign at_end     = (pos_q >= cnt_q);
	assign full       = (cnt_q == CW'(SLOTS));
	assign pol_walk   = policy inside {[POL_EARLIEST:POL_YOUNGER]};
	assign first_mode = (policy == POL_OLDER) || (policy == POL_YOUNGER);
	assign expired    = (rd_data.expiry <= req_q.now_seconds);
	assign eligible   = !rd_data.locked && (rd_data.prio <= req_q.priority_req);
	assign hit        = (rd_data.number == req_q.bundle_id);

	always_comb begin
		case (policy)
			POL_EARLIEST: better = !best_found_q || (rd_data.expiry < best_rec_q.expiry);
			POL_LATEST:   better = !best_found_q || (rd_data.expiry > best_rec_q.expiry);
			POL_OLDER:    better = (req_q.expiry_time >= rd_data.expiry);
			POL_YOUNGER:  better = (req_q.expiry_time < rd_data.expiry);
			default:      better = 1'b0;
		endcase
	end

	// first free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_found = 1'b1;
				free_idx   = SW'(k);
			end
		end
	end

	// home page, one byte a cycle from the top: r = (r * 256 + byte) mod PAGES
	assign dig_val = req_q.bundle_id[{dig_q, 3'b000} +: 8];
	assign shl_idx = 8'(page_q);
	assign shl_r   = SHL_TAB[shl_idx*PGW +: PGW];
	assign dig_r   = DIG_TAB[dig_val*PGW +: PGW];
	assign mod_t   = {1'b0, shl_r} + {1'b0, dig_r};
	assign mod_r   = (mod_t >= (PGW+1)'(PAGES)) ? (mod_t - (PGW+1)'(PAGES)) : mod_t;

	assign cnt_ext     = {5'b0, cnt_q};
	assign cnt_dec_ext = {5'b0, cnt_q - CW'(1)};

	always_comb begin
		new_rec           = '0;
		new_rec.number    = req_q.bundle_id;
		new_rec.expiry    = req_q.expiry_time;
		new_rec.prio      = req_q.priority_req;
		new_rec.locked    = 1'b0;
		new_rec.report    = req_q.wants_report;
		new_rec.local_src = req_q.from_local_node;
		new_rec.page      = PAGE_W'(page_q);
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.req_type)
						REQ_SAVE, REQ_PRUNE: st_d = S_PR_RD;
						REQ_DELETE, REQ_LOOKUP, REQ_LOCK, REQ_UNLOCK: st_d = S_FD_RD;
						default: st_d = S_DONE;
					endcase
				end
			end
			S_PR_RD: begin
				if (!at_end) begin
					st_d = S_PR_CHK;
				end else if (req_q.req_type != REQ_SAVE) begin
					st_d = S_DONE;
				end else if (!full) begin
					st_d = S_FD_RD;
				end else if (pol_walk) begin
					st_d = S_VI_RD;
				end else begin
					st_d = S_DONE;
				end
			end
			S_PR_CHK: begin
				if (!expired || emit_ready) st_d = S_PR_RD;
			end
			S_VI_RD: begin
				if (!at_end) st_d = S_VI_CHK;
				else st_d = best_found_q ? S_VI_REM : S_DONE;
			end
			S_VI_CHK: begin
				st_d = (first_mode && eligible && better) ? S_VI_REM : S_VI_RD;
			end
			S_VI_REM: begin
				if (emit_ready) st_d = S_FD_RD;
			end
			S_FD_RD: begin
				if (!at_end) st_d = S_FD_CHK;
				else st_d = (req_q.req_type == REQ_SAVE) ? S_MOD : S_DONE;
			end
			S_FD_CHK: begin
				if (hit) st_d = (req_q.req_type == REQ_DELETE) ? S_DEL : S_DONE;
				else st_d = S_FD_RD;
			end
			S_DEL: begin
				if (emit_ready) st_d = S_DONE;
			end
			S_MOD: begin
				if (dig_q == 2'd0) st_d = S_PROBE;
			end
			S_PROBE: begin
				if (tries_q == TW'(PAGES)) st_d = S_DONE;
				else if (!pused_q[page_q]) st_d = S_STORE;
			end
			S_STORE: st_d = S_DONE;
			S_DONE: begin
				if (emit_ready) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// outputs: result words, memory writes, removals
	always_comb begin
		in_ready   = (st_q == S_IDLE);
		emit_valid = 1'b0;
		emit_word  = '0;
		rm_en      = 1'b0;
		rm_pos     = pos_q;
		rm_rec     = rd_data;
		wr_en      = 1'b0;
		wr_addr    = rd_addr;
		wr_data    = rd_data;
		emit_word.event_kind     = KIND_NOTICE;
		emit_word.status         = ST_OK;
		emit_word.stored_count   = cnt_dec_ext[4:0];
		case (st_q)
			S_PR_CHK: begin
				emit_valid = expired;
				rm_en      = expired && emit_ready;
				emit_word.removal_reason = RSN_EXPIRED;
			end
			S_VI_REM: begin
				emit_valid = 1'b1;
				rm_en      = emit_ready;
				rm_pos     = best_pos_q;
				rm_rec     = best_rec_q;
				emit_word.removal_reason = RSN_DEPLETED;
			end
			S_DEL: begin
				emit_valid = 1'b1;
				rm_en      = emit_ready;
				rm_rec     = hit_rec_q;
				emit_word.removal_reason = req_q.delivered ? RSN_DELIVERED : RSN_OTHER;
			end
			S_FD_CHK: begin
				if (hit && (req_q.req_type == REQ_LOCK || req_q.req_type == REQ_UNLOCK)) begin
					wr_en          = 1'b1;
					wr_data.locked = (req_q.req_type == REQ_LOCK);
				end
			end
			S_STORE: begin
				wr_en   = free_found;
				wr_addr = free_idx;
				wr_data = new_rec;
			end
			default: begin
			end
		endcase
		emit_word.result_bundle = rm_rec.number;
		emit_word.result_page   = rm_rec.page[5:0];
		emit_word.report_needed = rm_rec.report && !rm_rec.local_src
			&& (emit_word.removal_reason != RSN_DELIVERED);
		// completion word
		if (st_q == S_DONE) begin
			emit_valid               = 1'b1;
			emit_word                = '0;
			emit_word.last           = 1'b1;
			emit_word.event_kind     = KIND_DONE;
			emit_word.status         = cstat_q;
			emit_word.result_bundle  = cnum_q;
			emit_word.result_page    = cpage_q;
			emit_word.stored_count   = cnt_ext[4:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// table bookkeeping: count, valid bits, page map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= '0;
			pused_q <= '0;
		end else if (rm_en) begin
			valid_q[ord_q[rm_pos[SW-1:0]]] <= 1'b0;
			pused_q[rm_rec.page[PGW-1:0]] <= 1'b0;
			cnt_q <= cnt_q - CW'(1);
		end else if (st_q == S_STORE && free_found) begin
			valid_q[free_idx] <= 1'b1;
			pused_q[page_q]   <= 1'b1;
			cnt_q             <= cnt_q + CW'(1);
		end
	end

	// insertion order list: compaction on removal, append on store
	always_ff @(posedge clk) begin
		if (rm_en) begin
			for (int k = 0; k < SLOTS - 1; k++) begin
				if (CW'(k) >= rm_pos) ord_q[k] <= ord_q[k+1];
			end
		end else if (st_q == S_STORE && free_found) begin
			ord_q[cnt_q[SW-1:0]] <= free_idx;
		end
	end

	// walk and completion registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			best_found_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= in_data;
						pos_q        <= '0;
						best_found_q <= 1'b0;
						cstat_q      <= ST_OK;
						cnum_q       <= '0;
						cpage_q      <= '0;
					end
				end
				S_PR_RD: begin
					if (at_end) begin
						pos_q <= '0;
						if (req_q.req_type == REQ_SAVE && full && !pol_walk) begin
							cstat_q <= ST_NO_ROOM;
							cnum_q  <= req_q.bundle_id;
						end
					end
				end
				S_PR_CHK: begin
					if (!expired) pos_q <= pos_q + CW'(1);
				end
				S_VI_RD: begin
					if (at_end && !best_found_q) begin
						cstat_q <= ST_NO_ROOM;
						cnum_q  <= req_q.bundle_id;
					end
				end
				S_VI_CHK: begin
					if (eligible && better) begin
						best_found_q <= 1'b1;
						best_pos_q   <= pos_q;
						best_rec_q   <= rd_data;
					end
					pos_q <= pos_q + CW'(1);
				end
				S_VI_REM: begin
					if (emit_ready) pos_q <= '0;
				end
				S_FD_RD: begin
					if (at_end) begin
						page_q <= '0;
						dig_q  <= 2'd3;
						if (req_q.req_type != REQ_SAVE) begin
							cstat_q <= ST_NOT_FOUND;
							cnum_q  <= req_q.bundle_id;
						end
					end
				end
				S_FD_CHK: begin
					if (hit) begin
						hit_rec_q <= rd_data;
						cnum_q    <= req_q.bundle_id;
						cpage_q   <= rd_data.page[5:0];
						cstat_q   <= (req_q.req_type == REQ_SAVE) ? ST_ALREADY : ST_OK;
					end else begin
						pos_q <= pos_q + CW'(1);
					end
				end
				S_MOD: begin
					page_q  <= mod_r[PGW-1:0];
					dig_q   <= dig_q - 2'd1;
					tries_q <= '0;
				end
				S_PROBE: begin
					if (tries_q == TW'(PAGES)) begin
						cstat_q <= ST_NO_ROOM;
						cnum_q  <= req_q.bundle_id;
					end else if (pused_q[page_q]) begin
						page_q  <= (page_q == PGW'(PAGES - 1)) ? '0 : page_q + PGW'(1);
						tries_q <= tries_q + TW'(1);
					end
				end
				S_STORE: begin
					cnum_q  <= req_q.bundle_id;
					cstat_q <= free_found ? ST_OK : ST_NO_ROOM;
					cpage_q <= free_found ? new_rec.page[5:0] : 6'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// count never exceeds the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS))
		else $error("entry count above table size");

	// valid bits and count agree
	a_cnt_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("valid bits disagree with entry count");

	// no word is produced while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !emit_valid)
		else $error("word emitted while idle");

	// a delivered completion returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && emit_ready && emit_word.last) |=> (st_q == S_IDLE))
		else $error("completion did not end the request");

endmodule

[hdl/bundle_slot_store_with_eviction_top.sv]
// Sequence: a save walks the entries to prune, then, when the table is full,
//   walks them again to pick and remove a victim, then searches for a duplicate,
//   forms the home page, probes past used pages, stores and completes.
// Delete, lookup, lock and unlock search the entries, then complete; every word waits
//   for room in the output register and appears in the cycle after it is taken.
// Throughput: one request at a time. Reset: control, valid bits, page map and
//   counts clear at once; policy is 1.
// ---------------------------------------------------------------------------
// bundle_slot_store_with_eviction_top
// Slot table of stored bundles with prune, eviction and page placement.
// ---------------------------------------------------------------------------
module bundle_slot_store_with_eviction_top #(
	parameter int SLOTS = 16,
	parameter int PAGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bss_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bss_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata
);
	import bss_pkg::*;

	logic       [2:0] policy_q;
	logic             emit_valid, emit_ready;
	out_word_t        emit_word;
	logic             ovalid_q;
	out_word_t        odata_q;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RESET;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	bss_ctrl #(.SLOTS(SLOTS), .PAGES(PAGES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.policy     (policy_q),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit_word  (emit_word)
	);

	// output word register
	assign emit_ready = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_ready) begin
			ovalid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) odata_q <= emit_word;
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

endmodule

[verif/tb_bundle_slot_store_with_eviction_top.sv]
// ---------------------------------------------------------------------------
// tb_bundle_slot_store_with_eviction_top
// Self-checking bench for the bundle slot store. Requests are driven over
// valid/ready with random gaps. A local table model predicts every notice and
// completion word, and a checker compares each returned word field by field.
// ---------------------------------------------------------------------------
module tb_bundle_slot_store_with_eviction_top;
	import bss_pkg::*;

	localparam int SLOTS = 16;
	localparam int PAGES = 64;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 400;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_we;
	logic [2:0] cfg_wdata;

	bundle_slot_store_with_eviction_top #(.SLOTS(SLOTS), .PAGES(PAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// model of the slot table
	logic [2:0]  m_policy;
	logic        m_valid [SLOTS];
	logic [31:0] m_num [SLOTS];
	logic [31:0] m_exp [SLOTS];
	logic [1:0]  m_prio [SLOTS];
	logic        m_lock [SLOTS];
	logic        m_rpt [SLOTS];
	logic        m_loc [SLOTS];
	logic [5:0]  m_page [SLOTS];
	logic [31:0] m_age [SLOTS];
	logic        m_page_used [PAGES];
	int unsigned m_count;
	logic [31:0] m_next_age;
	int          age_q[$];

	out_word_t   expected_words[$];
	int          errors = 0;
	int unsigned cycles = 0;
	bit          full_speed = 0;
	int          stall_left = 0;
	logic [31:0] now_s;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (full_speed) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_ready <= 1'b1;
			end else if (r < 95) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(10, 40);
			end
		end
	end

	function automatic void cmp_field(string name, longint unsigned e, longint unsigned a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: expected none actual %h", $time, out_data);
				errors++;
			end else begin
				out_word_t e;
				e = expected_words.pop_front();
				cmp_field("last", e.last, out_data.last);
				cmp_field("event_kind", e.event_kind, out_data.event_kind);
				cmp_field("status", e.status, out_data.status);
				cmp_field("result_bundle", e.result_bundle, out_data.result_bundle);
				cmp_field("result_page", e.result_page, out_data.result_page);
				cmp_field("removal_reason", e.removal_reason, out_data.removal_reason);
				cmp_field("report_needed", e.report_needed, out_data.report_needed);
				cmp_field("stored_count", e.stored_count, out_data.stored_count);
			end
		end
	end

	// ---------------- model ----------------

	function automatic void push_word(logic last, logic kind, logic [1:0] st,
			logic [31:0] num, logic [5:0] page, logic [1:0] rsn, logic rep);
		out_word_t w;
		w.last = last;
		w.event_kind = kind;
		w.status = st;
		w.result_bundle = num;
		w.result_page = page;
		w.removal_reason = rsn;
		w.report_needed = rep;
		w.stored_count = m_count[4:0];
		expected_words.push_back(w);
	endfunction

	// valid slots, oldest first
	function automatic void sort_by_age();
		int k;
		age_q.delete();
		for (int s = 0; s < SLOTS; s++) begin
			if (m_valid[s]) begin
				k = age_q.size();
				while (k > 0 && m_age[age_q[k-1]] > m_age[s]) k--;
				age_q.insert(k, s);
			end
		end
	endfunction

	function automatic int find_num(logic [31:0] num);
		sort_by_age();
		foreach (age_q[i]) if (m_num[age_q[i]] == num) return age_q[i];
		return -1;
	endfunction

	function automatic void drop_slot(int s, logic [1:0] rsn);
		logic rep;
		rep = m_rpt[s] && !m_loc[s] && rsn != RSN_DELIVERED;
		m_valid[s] = 1'b0;
		m_page_used[m_page[s]] = 1'b0;
		if (m_count > 0) m_count--;
		push_word(1'b0, KIND_NOTICE, ST_OK, m_num[s], m_page[s], rsn, rep);
	endfunction

	function automatic void expire_until(logic [31:0] now);
		int ol[$];
		sort_by_age();
		ol = age_q;
		foreach (ol[i]) if (m_exp[ol[i]] <= now) drop_slot(ol[i], RSN_EXPIRED);
	endfunction

	function automatic int choose_victim(logic [1:0] prio, logic [31:0] new_exp);
		int best;
		int s;
		best = -1;
		sort_by_age();
		foreach (age_q[i]) begin
			s = age_q[i];
			if (m_lock[s] || m_prio[s] > prio) continue;
			case (m_policy)
				POL_EARLIEST: if (best < 0 || m_exp[s] < m_exp[best]) best = s;
				POL_LATEST:   if (best < 0 || m_exp[s] > m_exp[best]) best = s;
				POL_OLDER:    if (new_exp >= m_exp[s]) return s;
				POL_YOUNGER:  if (new_exp < m_exp[s]) return s;
				default:      return -1;
			endcase
		end
		return best;
	endfunction

	function automatic void predict_save(in_word_t w);
		int v;
		int d;
		int s;
		int tries;
		logic [5:0] page;
		expire_until(w.now_seconds);
		if (m_count >= SLOTS) begin
			v = choose_victim(w.priority_req, w.expiry_time);
			if (v >= 0) drop_slot(v, RSN_DEPLETED);
		end
		if (m_count >= SLOTS) begin
			push_word(1'b1, KIND_DONE, ST_NO_ROOM, w.bundle_id, 6'd0, RSN_EXPIRED, 1'b0);
			return;
		end
		d = find_num(w.bundle_id);
		if (d >= 0) begin
			push_word(1'b1, KIND_DONE, ST_ALREADY, w.bundle_id, m_page[d], RSN_EXPIRED, 1'b0);
			return;
		end
		page = w.bundle_id % PAGES;
		tries = 0;
		while (tries < PAGES && m_page_used[page]) begin
			page = (page + 1) % PAGES;
			tries++;
		end
		s = 0;
		while (s < SLOTS && m_valid[s]) s++;
		if (tries >= PAGES || s >= SLOTS) begin
			push_word(1'b1, KIND_DONE, ST_NO_ROOM, w.bundle_id, 6'd0, RSN_EXPIRED, 1'b0);
			return;
		end
		// renumber ages when the counter is at its end
		if (m_next_age == 32'hFFFF_FFFF) begin
			sort_by_age();
			foreach (age_q[i]) m_age[age_q[i]] = i;
			m_next_age = age_q.size();
		end
		m_valid[s] = 1'b1;
		m_num[s] = w.bundle_id;
		m_exp[s] = w.expiry_time;
		m_prio[s] = w.priority_req;
		m_lock[s] = 1'b0;
		m_rpt[s] = w.wants_report;
		m_loc[s] = w.from_local_node;
		m_page[s] = page;
		m_age[s] = m_next_age;
		m_next_age = m_next_age + 1;
		m_page_used[page] = 1'b1;
		m_count++;
		push_word(1'b1, KIND_DONE, ST_OK, w.bundle_id, page, RSN_EXPIRED, 1'b0);
	endfunction

	function automatic void predict_request(in_word_t w);
		int s;
		logic [5:0] page;
		case (w.req_type)
			REQ_SAVE: predict_save(w);
			REQ_DELETE: begin
				s = find_num(w.bundle_id);
				if (s < 0) begin
					push_word(1'b1, KIND_DONE, ST_NOT_FOUND, w.bundle_id, 6'd0, RSN_EXPIRED, 1'b0);
				end else begin
					page = m_page[s];
					drop_slot(s, w.delivered ? RSN_DELIVERED : RSN_OTHER);
					push_word(1'b1, KIND_DONE, ST_OK, w.bundle_id, page, RSN_EXPIRED, 1'b0);
				end
			end
			REQ_LOOKUP, REQ_LOCK, REQ_UNLOCK: begin
				s = find_num(w.bundle_id);
				if (s < 0) begin
					push_word(1'b1, KIND_DONE, ST_NOT_FOUND, w.bundle_id, 6'd0, RSN_EXPIRED, 1'b0);
				end else begin
					if (w.req_type == REQ_LOCK) m_lock[s] = 1'b1;
					if (w.req_type == REQ_UNLOCK) m_lock[s] = 1'b0;
					push_word(1'b1, KIND_DONE, ST_OK, w.bundle_id, m_page[s], RSN_EXPIRED, 1'b0);
				end
			end
			REQ_PRUNE: begin
				expire_until(w.now_seconds);
				push_word(1'b1, KIND_DONE, ST_OK, 32'd0, 6'd0, RSN_EXPIRED, 1'b0);
			end
			default: push_word(1'b1, KIND_DONE, ST_OK, 32'd0, 6'd0, RSN_EXPIRED, 1'b0);
		endcase
	endfunction

	// ---------------- driving ----------------

	// send one word, leave valid high; caller is at a clock edge
	task automatic send_word(in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		predict_request(w);
	endtask

	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!full_speed) begin
			if (r >= 55 && r < 90) n = $urandom_range(1, 3);
			else if (r >= 90) n = $urandom_range(10, 40);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_gap(in_word_t w);
		send_word(w);
		sender_gap();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_policy(logic [2:0] p);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_policy = p;
	endtask

	function automatic in_word_t mk(logic [2:0] rq, logic [31:0] num, logic [1:0] prio,
			logic rep, logic loc, logic [31:0] ex, logic [31:0] now, logic dlv);
		in_word_t w;
		w.req_type = rq;
		w.bundle_id = num;
		w.priority_req = prio;
		w.wants_report = rep;
		w.from_local_node = loc;
		w.expiry_time = ex;
		w.now_seconds = now;
		w.delivered = dlv;
		return w;
	endfunction

	function automatic logic [31:0] pick_num();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return $urandom();
		if (r < 25) return ($urandom_range(0, 3) << 6) | $urandom_range(0, 3);
		return $urandom_range(0, 29);
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		int r;
		w = $urandom();
		w.bundle_id = pick_num();
		w.priority_req = $urandom_range(0, 3);
		w.wants_report = $urandom_range(0, 1);
		w.from_local_node = $urandom_range(0, 1);
		w.delivered = $urandom_range(0, 1);
		now_s = now_s + $urandom_range(0, 4);
		w.now_seconds = now_s;
		w.expiry_time = now_s + $urandom_range(1, 300);
		r = $urandom_range(0, 99);
		if (r < 5) w.expiry_time = $urandom();
		else if (r < 8) w.now_seconds = $urandom();
		r = $urandom_range(0, 99);
		if (r < 45)      w.req_type = REQ_SAVE;
		else if (r < 55) w.req_type = REQ_DELETE;
		else if (r < 65) w.req_type = REQ_LOOKUP;
		else if (r < 78) w.req_type = REQ_LOCK;
		else if (r < 86) w.req_type = REQ_UNLOCK;
		else if (r < 96) w.req_type = REQ_PRUNE;
		else             w.req_type = $urandom_range(6, 7);
		return w;
	endfunction

	// ---------------- tests ----------------

	// fixed cases: extremes, every request, duplicates, page probing, reports
	task automatic test_directed();
		send_gap(mk(REQ_SAVE, 32'd0, 2'd0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd100, 1'b0));
		send_gap(mk(REQ_SAVE, 32'd64, 2'd1, 1'b1, 1'b1, 32'd1000, 32'd100, 1'b0));
		send_gap(mk(REQ_SAVE, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b0, 32'd150, 32'd100, 1'b1));
		send_gap(mk(REQ_SAVE, 32'd128, 2'd2, 1'b0, 1'b0, 32'd2000, 32'd100, 1'b0));
		send_gap(mk(REQ_SAVE, 32'd0, 2'd0, 1'b0, 1'b0, 32'd500, 32'd100, 1'b0));
		send_gap(mk(REQ_LOOKUP, 32'd12345, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_LOOKUP, 32'd64, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_LOCK, 32'd64, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_UNLOCK, 32'd64, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_LOCK, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_DELETE, 32'd64, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1));
		send_gap(mk(REQ_DELETE, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(3'd6, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_gap(mk(3'd7, 32'd5, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_PRUNE, 32'd9, 2'd0, 1'b0, 1'b0, 32'd0, 32'd150, 1'b0));
		send_gap(mk(REQ_DELETE, 32'd77, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1));
		send_gap(mk(REQ_LOCK, 32'd77, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_UNLOCK, 32'd77, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_SAVE, 32'd3, 2'd1, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0));
		send_gap(mk(REQ_PRUNE, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0));
	endtask

	// fill the table, lock a few, then save against it under one policy
	task automatic test_eviction(logic [2:0] pol);
		logic [31:0] base;
		set_policy(pol);
		now_s = $urandom_range(0, 1000);
		send_gap(mk(REQ_PRUNE, 32'd0, 2'd0, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0));
		base = $urandom();
		for (int i = 0; i < SLOTS; i++)
			send_gap(mk(REQ_SAVE, base + i, $urandom_range(0, 3), $urandom_range(0, 1),
				$urandom_range(0, 1), now_s + $urandom_range(10, 1000), now_s, 1'b0));
		for (int i = 0; i < 3; i++)
			send_gap(mk(REQ_LOCK, base + $urandom_range(0, SLOTS - 1), 2'd0, 1'b0, 1'b0,
				32'd0, 32'd0, 1'b0));
		for (int i = 0; i < 5; i++)
			send_gap(mk(REQ_SAVE, base + 100 + i, $urandom_range(0, 3), $urandom_range(0, 1),
				$urandom_range(0, 1), now_s + $urandom_range(10, 1000), now_s, 1'b0));
		send_gap(mk(REQ_SAVE, base + 3, 2'd3, 1'b0, 1'b0, now_s + 50, now_s, 1'b0));
	endtask

	task automatic test_random(int n);
		logic [2:0] pols[$] = '{POL_EARLIEST, POL_LATEST, POL_OLDER, POL_YOUNGER,
			POL_NEVER, 3'd5};
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 0) set_policy(pols[(i / 80) % pols.size()]);
			full_speed = ((i / 40) % 5 == 2);
			send_gap(rand_word());
		end
		full_speed = 0;
	endtask

	// hold the sender until all expected words are back, then resume
	task automatic test_pause();
		for (int i = 0; i < 10; i++) send_gap(rand_word());
		drain();
		for (int i = 0; i < 10; i++) send_gap(rand_word());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 3'd0;
		m_policy = POL_RESET;
		for (int s = 0; s < SLOTS; s++) m_valid[s] = 1'b0;
		for (int p = 0; p < PAGES; p++) m_page_used[p] = 1'b0;
		m_count = 0;
		m_next_age = 32'd0;
		now_s = 32'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_eviction(POL_NEVER);
		test_eviction(POL_EARLIEST);
		test_eviction(POL_LATEST);
		test_eviction(POL_OLDER);
		test_eviction(POL_YOUNGER);
		test_eviction(3'd7);
		test_pause();
		test_random(300);

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[files.f]
hdl/bss_pkg.sv
hdl/bss_mem.sv
hdl/bss_ctrl.sv
hdl/bundle_slot_store_with_eviction_top.sv
verif/tb_bundle_slot_store_with_eviction_top.sv
